// ===== rtl/core/maf_pkg.sv =====
// Shared constants, register codes and controller state type for the
// masked 3x3 average filter. No dependencies.
`default_nettype none

package maf_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int FRAC_BITS       = 8;

  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;   // holds MAX_HEIGHT - 1

  localparam int GRID_REG_W = 11;
  localparam logic [GRID_REG_W-1:0] GRID_RESET = 11'd64;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;

  // Count of positive samples in the window, 0..9
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } maf_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/maf_if.sv =====
// Channel interfaces of the filter: sample input, result output and
// configuration write. Depends on maf_pkg.
`default_nettype none

interface maf_in_if #(
  parameter int SAMPLE_BITS = maf_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] depth_in;

  modport source (output valid, output depth_in, input ready);
  modport sink   (input valid, input depth_in, output ready);
endinterface

interface maf_out_if #(
  parameter int SAMPLE_BITS = maf_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] avg_depth;
  logic                          is_last;

  modport source (output valid, output avg_depth, output is_last, input ready);
  modport sink   (input valid, input avg_depth, input is_last, output ready);
endinterface

interface maf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [maf_pkg::CFG_IDX_W-1:0]   index;
  logic [maf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/maf_line_mem.sv =====
// Two single-port line stores (row above, row two above), shared address,
// registered read. No package dependencies.
`default_nettype none

module maf_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_prev_i,
  input  wire logic [DATA_W-1:0]        wdata_prev2_i,
  output logic      [DATA_W-1:0]        rdata_prev_o,
  output logic      [DATA_W-1:0]        rdata_prev2_o
);

  logic [DATA_W-1:0] prev_mem  [DEPTH];
  logic [DATA_W-1:0] prev2_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      prev_mem[addr_i]  <= wdata_prev_i;
      prev2_mem[addr_i] <= wdata_prev2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_prev_o  <= prev_mem[addr_i];
      rdata_prev2_o <= prev2_mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/maf_div.sv =====
// Restoring divider, one quotient bit per cycle, for window sum / count.
// Divisor width from maf_pkg.
`default_nettype none

module maf_div #(
  parameter int DIVIDEND_W = 19
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DIVIDEND_W-1:0]       dividend_i,
  input  wire logic [maf_pkg::CNT_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic      [DIVIDEND_W-1:0]       quot_o
);

  localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [maf_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [maf_pkg::CNT_W-1:0]   dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0]       quo_q, quo_d;
  logic [maf_pkg::CNT_W:0]     rem_sh;
  logic                        fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? maf_pkg::CNT_W'(rem_sh - {1'b0, dvs_q})
                    : rem_sh[maf_pkg::CNT_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/masked_3x3_average_filter_top.sv =====
// Masked 3x3 average filter: raster depth samples in, one result per interior pixel out.
// A new sample is accepted only in ST_IDLE, after the last one is through: a border sample
// (no result), an invalid-center marker, or an averaged pixel from the bit-serial divider
// (SAMPLE_BITS + 3 steps). Results leave via an output register; line store reads are registered.
// Reset: async active low; counters, window and control clear, grid size 64 x 64.
// Line stores are not cleared; stale entries read in the first two rows of a frame reach no result.
// Depends on maf_pkg, maf_if, maf_line_mem, maf_div.
`default_nettype none

module masked_3x3_average_filter_top #(
  parameter int MAX_WIDTH   = maf_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = maf_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  maf_in_if.sink     in_i,
  maf_out_if.source  out_o,
  maf_cfg_if.sink    cfg_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);           // column index width
  localparam int RW    = maf_pkg::ROW_W;
  localparam int GW    = maf_pkg::GRID_REG_W;
  localparam int WCMP  = (CW + 1 > GW) ? CW + 1 : GW;  // width clamp compare width
  localparam int CSUMW = SB + 1;                      // three positive samples
  localparam int SUMW  = SB + 3;                      // nine positive samples
  localparam int CNTW  = maf_pkg::CNT_W;

  // -1.0 in Q8.8, saturated to the most negative sample if it does not fit
  localparam logic [SB-1:0] MARKER = (SB >= maf_pkg::FRAC_BITS + 1) ?
    SB'(-(1 << maf_pkg::FRAC_BITS)) : {1'b1, {(SB-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration: grid size registers, always ready. A write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [GW-1:0] width_q, height_q;
  logic          cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid &&
                   (cfg_i.index == maf_pkg::REG_GRID_WIDTH ||
                    cfg_i.index == maf_pkg::REG_GRID_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= maf_pkg::GRID_RESET;
      height_q <= maf_pkg::GRID_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == maf_pkg::REG_GRID_WIDTH) begin
        width_q <= cfg_i.data[GW-1:0];
      end
      if (cfg_i.index == maf_pkg::REG_GRID_HEIGHT) begin
        height_q <= cfg_i.data[GW-1:0];
      end
    end
  end

  // Last column / row index after clamping to the legal range
  logic [WCMP-1:0] w_ext, w_clamp;
  logic [GW-1:0]   h_clamp;
  logic [CW-1:0]   col_last;
  logic [RW-1:0]   row_last;

  always_comb begin
    w_ext = WCMP'(width_q);
    if (w_ext < WCMP'(3)) begin
      w_clamp = WCMP'(3);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_clamp = WCMP'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (height_q < GW'(3)) begin
      h_clamp = GW'(3);
    end else if (height_q > GW'(maf_pkg::MAX_HEIGHT)) begin
      h_clamp = GW'(maf_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = height_q;
    end
    col_last = CW'(w_clamp - 1'b1);
    row_last = RW'(h_clamp - 1'b1);
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  maf_pkg::maf_state_e state_q, state_d;

  logic in_acc;
  logic mem_en, mem_we;
  logic div_start, div_done;
  logic out_load;
  logic emit, center_ok;

  logic [CW-1:0] col_q, col_d, c_now, c_q;
  logic [RW-1:0] row_q, row_d, r_now, r_q;
  logic [SB-1:0] x_q;
  logic          last_q;

  assign in_acc = in_i.valid && in_i.ready;

  // Position of the incoming sample; stale counters fall back to column/row 0
  assign c_now = (col_q > col_last) ? '0 : col_q;
  assign r_now = (row_q > row_last) ? '0 : row_q;

  // Evaluated in ST_READ with the latched position and the pre-shift window
  logic signed [SB-1:0] win_q [6];
  assign emit      = (c_q >= CW'(2)) && (r_q >= RW'(2));
  assign center_ok = win_q[4] > 0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      maf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = maf_pkg::ST_READ;
        end
      end
      maf_pkg::ST_READ: begin
        if (!emit) begin
          state_d = maf_pkg::ST_IDLE;
        end else if (center_ok) begin
          state_d = maf_pkg::ST_SUM;
        end else begin
          state_d = maf_pkg::ST_DONE;
        end
      end
      maf_pkg::ST_SUM:  state_d = maf_pkg::ST_DIV;
      maf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = maf_pkg::ST_DONE;
        end
      end
      maf_pkg::ST_DONE: begin
        if (!out_o.valid || out_o.ready) begin
          state_d = maf_pkg::ST_IDLE;
        end
      end
      default: state_d = maf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      maf_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        mem_en     = in_acc;          // read both rows at c_now
      end
      maf_pkg::ST_READ: begin
        mem_en = 1'b1;                // write back at c_q
        mem_we = 1'b1;
      end
      maf_pkg::ST_SUM:  div_start = 1'b1;
      maf_pkg::ST_DIV:  ;
      maf_pkg::ST_DONE: out_load = !out_o.valid || out_o.ready;
      default: ;
    endcase
  end

  // Frame counters advance on each accepted transaction; a grid size write clears them instead
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (c_now == col_last) begin
        col_d = '0;
        row_d = (r_now == row_last) ? '0 : r_now + 1'b1;
      end else begin
        col_d = c_now + 1'b1;
        row_d = r_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maf_pkg::ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_i.depth_in;
      c_q    <= c_now;
      r_q    <= r_now;
      last_q <= (c_now == col_last) && (r_now == row_last);
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read on accept, rotate (prev -> prev2, sample -> prev) in ST_READ
  // ---------------------------------------------------------------------------
  logic [SB-1:0] top_rd, mid_rd;

  maf_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SB)
  ) u_line_mem (
    .clk_i         (clk_i),
    .en_i          (mem_en),
    .we_i          (mem_we),
    .addr_i        (mem_we ? c_q : c_now),
    .wdata_prev_i  (x_q),
    .wdata_prev2_i (mid_rd),
    .rdata_prev_o  (mid_rd),
    .rdata_prev2_o (top_rd)
  );

  // ---------------------------------------------------------------------------
  // Window: entries 0..2 column c-2, 3..5 column c-1 (top, middle, bottom)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (state_q == maf_pkg::ST_READ) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i] <= win_q[i+3];
      end
      win_q[3] <= $signed(top_rd);
      win_q[4] <= $signed(mid_rd);
      win_q[5] <= $signed(x_q);
    end
  end

  // Per-column sums of the positive samples, registered before the final add
  function automatic logic [SB-1:0] pos_val(input logic [SB-1:0] s);
    return (!s[SB-1] && (|s)) ? s : '0;
  endfunction

  function automatic logic pos_bit(input logic [SB-1:0] s);
    return !s[SB-1] && (|s);
  endfunction

  logic [SB-1:0]    col_smp [3][3];
  logic [CSUMW-1:0] csum_d [3], csum_q [3];
  logic [1:0]       ccnt_d [3], ccnt_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_smp[0][k] = win_q[k];
      col_smp[1][k] = win_q[k+3];
    end
    col_smp[2][0] = top_rd;
    col_smp[2][1] = mid_rd;
    col_smp[2][2] = x_q;
    for (int j = 0; j < 3; j++) begin
      csum_d[j] = CSUMW'(pos_val(col_smp[j][0])) + CSUMW'(pos_val(col_smp[j][1]))
                + CSUMW'(pos_val(col_smp[j][2]));
      ccnt_d[j] = 2'(pos_bit(col_smp[j][0])) + 2'(pos_bit(col_smp[j][1]))
                + 2'(pos_bit(col_smp[j][2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == maf_pkg::ST_READ) begin
      for (int j = 0; j < 3; j++) begin
        csum_q[j] <= csum_d[j];
        ccnt_q[j] <= ccnt_d[j];
      end
    end
  end

  logic [SUMW-1:0] win_sum;
  logic [CNTW-1:0] win_cnt;
  logic [SUMW-1:0] quot;

  assign win_sum = SUMW'(csum_q[0]) + SUMW'(csum_q[1]) + SUMW'(csum_q[2]);
  assign win_cnt = CNTW'(ccnt_q[0]) + CNTW'(ccnt_q[1]) + CNTW'(ccnt_q[2]);

  maf_div #(
    .DIVIDEND_W (SUMW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (win_sum),
    .divisor_i  (win_cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // ---------------------------------------------------------------------------
  // Result and output register
  // ---------------------------------------------------------------------------
  logic [SB-1:0] res_q;
  logic          out_valid_q;
  logic [SB-1:0] avg_q;
  logic          is_last_q;

  // Mean never exceeds the largest sample, so the low bits hold it
  always_ff @(posedge clk_i) begin
    if (state_q == maf_pkg::ST_READ) begin
      res_q <= MARKER;
    end else if (state_q == maf_pkg::ST_DIV && div_done) begin
      res_q <= quot[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q     <= res_q;
      is_last_q <= last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.avg_depth = avg_q;
  assign out_o.is_last   = is_last_q;

endmodule

`default_nettype wire
